/* hw/rtl/fbc_pkg.sv */
// Shared widths, constants and types for the frustum box culling block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package fbc_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int ELEM_W      = 32;
    localparam int COEF_W      = ELEM_W + 1;
    localparam int PROD_W      = COEF_W + ELEM_W;
    localparam int PART_W      = PROD_W + 1;
    localparam int DIST_W      = PART_W + 1;
    localparam int NUM_PLANES  = 6;
    localparam int NUM_PAIRS   = 8;
    localparam int PAIR_IDX_W  = $clog2(NUM_PAIRS);
    localparam int CFG_IDX_W   = PAIR_IDX_W + 1;
    localparam int CFG_DATA_W  = 2 * ELEM_W;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] d;
    } plane_coef_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] x;
        logic signed [ELEM_W-1:0] y;
        logic signed [ELEM_W-1:0] z;
    } corner_t;

    typedef struct packed {
        logic ld1;
        logic ld2;
    } pipe_ctl_t;

endpackage

/* hw/rtl/frustum_box_cull.sv */
// Top level of the frustum box culling block: handshakes, pipeline valid
// tracking and the output register. Depends on fbc_pkg, fbc_cfg, fbc_plane_eval.
// Channel   Signals                                  Direction
// cfg       cfg_valid cfg_ready cfg_index cfg_data   write in
// in        in_valid in_ready min_* max_*            item in
// out       out_valid out_ready visible              item out
// One item is accepted per cycle while neither a stalled output nor a configuration
// write holds the input; each result passes the input register, the multiply stage
// and the partial sum stage into the output register.
// Reset clears the matrix to zero and empties the pipeline.
// Each stage holds its item while the next stage is full and stalled, so bubbles
// close up behind a stalled output. An item is not accepted in a cycle that
// carries a configuration write.
`timescale 1ns / 1ps

module frustum_box_cull
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [fbc_pkg::ELEM_W-1:0] min_x,
    input  logic signed [fbc_pkg::ELEM_W-1:0] min_y,
    input  logic signed [fbc_pkg::ELEM_W-1:0] min_z,
    input  logic signed [fbc_pkg::ELEM_W-1:0] max_x,
    input  logic signed [fbc_pkg::ELEM_W-1:0] max_y,
    input  logic signed [fbc_pkg::ELEM_W-1:0] max_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              visible
);

    fbc_pkg::plane_coef_t planes [fbc_pkg::NUM_PLANES];
    fbc_pkg::corner_t     box_min_reg, box_max_reg;
    fbc_pkg::pipe_ctl_t   ctl;
    logic [fbc_pkg::NUM_PLANES-1:0] outside;

    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s0_valid_next, s1_valid_next, s2_valid_next, s3_valid_next;
    logic ready0, ready1, ready2, ready3;
    logic in_take;
    logic visible_reg, visible_next;

    assign cfg_ready = 1'b1;

    fbc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    assign ready3 = !s3_valid_reg || out_ready;
    assign ready2 = !s2_valid_reg || ready3;
    assign ready1 = !s1_valid_reg || ready2;
    assign ready0 = !s0_valid_reg || ready1;

    assign in_ready = ready0 && !cfg_valid;
    assign in_take  = in_valid && in_ready;

    assign ctl.ld1 = ready1 && s0_valid_reg;
    assign ctl.ld2 = ready2 && s1_valid_reg;

    assign s0_valid_next = ready0 ? in_take      : s0_valid_reg;
    assign s1_valid_next = ready1 ? s0_valid_reg : s1_valid_reg;
    assign s2_valid_next = ready2 ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = ready3 ? s2_valid_reg : s3_valid_reg;

    genvar gp;
    generate
        for (gp = 0; gp < fbc_pkg::NUM_PLANES; gp++)
        begin : g_plane
            fbc_plane_eval u_plane
            (
                .clk     (clk),
                .ctl     (ctl),
                .coef    (planes[gp]),
                .box_min (box_min_reg),
                .box_max (box_max_reg),
                .outside (outside[gp])
            );
        end
    endgenerate

    assign visible_next = ~|outside;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            box_min_reg.x <= min_x;
            box_min_reg.y <= min_y;
            box_min_reg.z <= min_z;
            box_max_reg.x <= max_x;
            box_max_reg.y <= max_y;
            box_max_reg.z <= max_z;
        end
        if (ready3 && s2_valid_reg)
        begin
            visible_reg <= visible_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign visible   = visible_reg;

endmodule

/* hw/rtl/fbc_cfg.sv */
// Matrix configuration registers and registered clip plane extraction.
// Depends on fbc_pkg.
`timescale 1ns / 1ps

module fbc_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr,
    input  logic [fbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output fbc_pkg::plane_coef_t              planes [fbc_pkg::NUM_PLANES]
);

    logic [fbc_pkg::CFG_DATA_W-1:0] mat_pair_reg [fbc_pkg::NUM_PAIRS];
    fbc_pkg::plane_coef_t           plane_reg    [fbc_pkg::NUM_PLANES];
    fbc_pkg::plane_coef_t           plane_next   [fbc_pkg::NUM_PLANES];
    logic signed [fbc_pkg::ELEM_W-1:0] m [4][4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fbc_pkg::NUM_PAIRS; i++)
            begin
                mat_pair_reg[i] <= '0;
            end
        end
        else if (cfg_wr && (cfg_index < fbc_pkg::CFG_IDX_W'(fbc_pkg::NUM_PAIRS)))
        begin
            mat_pair_reg[cfg_index[fbc_pkg::PAIR_IDX_W-1:0]] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if ((r & 1) != 0)
                begin
                    m[c][r] = mat_pair_reg[fbc_pkg::PAIR_IDX_W'(c * 2 + (r >> 1))]
                              [fbc_pkg::CFG_DATA_W-1:fbc_pkg::ELEM_W];
                end
                else
                begin
                    m[c][r] = mat_pair_reg[fbc_pkg::PAIR_IDX_W'(c * 2 + (r >> 1))]
                              [fbc_pkg::ELEM_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        logic signed [fbc_pkg::COEF_W-1:0] k_coef [4];
        logic signed [fbc_pkg::COEF_W-1:0] base;
        logic signed [fbc_pkg::COEF_W-1:0] other;
        for (int p = 0; p < fbc_pkg::NUM_PLANES; p++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                base  = fbc_pkg::COEF_W'(m[k][3]);
                other = fbc_pkg::COEF_W'(m[k][p >> 1]);
                if ((p & 1) != 0)
                begin
                    k_coef[k] = base - other;
                end
                else
                begin
                    k_coef[k] = base + other;
                end
            end
            plane_next[p].a = k_coef[0];
            plane_next[p].b = k_coef[1];
            plane_next[p].c = k_coef[2];
            plane_next[p].d = k_coef[3];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < fbc_pkg::NUM_PLANES; p++)
        begin
            plane_reg[p] <= plane_next[p];
        end
    end

    always_comb
    begin
        for (int p = 0; p < fbc_pkg::NUM_PLANES; p++)
        begin
            planes[p] = plane_reg[p];
        end
    end

endmodule

/* hw/rtl/fbc_plane_eval.sv */
// Signed distance of the positive box vertex to one clip plane, over two
// register stages; the last add and sign test feed the output stage.
// Depends on fbc_pkg.
`timescale 1ns / 1ps

module fbc_plane_eval
(
    input  logic                  clk,
    input  fbc_pkg::pipe_ctl_t    ctl,
    input  fbc_pkg::plane_coef_t  coef,
    input  fbc_pkg::corner_t      box_min,
    input  fbc_pkg::corner_t      box_max,
    output logic                  outside
);

    logic signed [fbc_pkg::COEF_W-1:0] ca, cb, cc, cd;
    logic signed [fbc_pkg::ELEM_W-1:0] px, py, pz;

    logic signed [fbc_pkg::PROD_W-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [fbc_pkg::PROD_W-1:0] prod_x_next, prod_y_next, prod_z_next;
    logic signed [fbc_pkg::PART_W-1:0] d_sh_reg, d_sh_next;
    logic signed [fbc_pkg::PART_W-1:0] part_xy_reg, part_zd_reg;
    logic signed [fbc_pkg::PART_W-1:0] part_xy_next, part_zd_next;
    logic signed [fbc_pkg::DIST_W-1:0] dist_sum;

    assign ca = coef.a;
    assign cb = coef.b;
    assign cc = coef.c;
    assign cd = coef.d;

    // The positive vertex takes the max corner where the normal is not negative.
    assign px = ca[fbc_pkg::COEF_W-1] ? box_min.x : box_max.x;
    assign py = cb[fbc_pkg::COEF_W-1] ? box_min.y : box_max.y;
    assign pz = cc[fbc_pkg::COEF_W-1] ? box_min.z : box_max.z;

    assign prod_x_next = fbc_pkg::PROD_W'(ca) * fbc_pkg::PROD_W'(px);
    assign prod_y_next = fbc_pkg::PROD_W'(cb) * fbc_pkg::PROD_W'(py);
    assign prod_z_next = fbc_pkg::PROD_W'(cc) * fbc_pkg::PROD_W'(pz);
    assign d_sh_next   = fbc_pkg::PART_W'(cd) <<< fbc_pkg::FRAC_BITS;

    assign part_xy_next = fbc_pkg::PART_W'(prod_x_reg) + fbc_pkg::PART_W'(prod_y_reg);
    assign part_zd_next = fbc_pkg::PART_W'(prod_z_reg) + d_sh_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.ld1)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
            d_sh_reg   <= d_sh_next;
        end
        if (ctl.ld2)
        begin
            part_xy_reg <= part_xy_next;
            part_zd_reg <= part_zd_next;
        end
    end

    assign dist_sum = fbc_pkg::DIST_W'(part_xy_reg) + fbc_pkg::DIST_W'(part_zd_reg);
    assign outside  = dist_sum[fbc_pkg::DIST_W-1];

endmodule

/* tb/tb.sv */
// Self-checking testbench for frustum_box_cull: a directed table, then random boxes
// under several matrices, checked against a built-in plane-distance predictor.
// Depends on fbc_pkg and the frustum_box_cull RTL only.
`timescale 1ns / 1ps

module tb;
    import fbc_pkg::*;

    localparam int PIPE_LAT    = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 250;
    localparam int NUM_PHASES  = 7;
    localparam int MAX_PRINTS  = 100;
    localparam int Q_UNIT      = 1 << FRAC_BITS;

    localparam logic signed [ELEM_W-1:0] Q_ONE = Q_UNIT;
    localparam logic signed [ELEM_W-1:0] Q_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
    localparam logic signed [ELEM_W-1:0] Q_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

    typedef enum int {MAT_ZERO, MAT_IDENT, MAT_POS_LIMIT, MAT_NEG_LIMIT} mat_preset_e;
    typedef enum int {MIX_CAMERA, MIX_SMALL, MIX_WIDE, MIX_LIMITS} mat_mix_e;

    typedef struct packed {
        logic signed [ELEM_W-1:0] min_x;
        logic signed [ELEM_W-1:0] min_y;
        logic signed [ELEM_W-1:0] min_z;
        logic signed [ELEM_W-1:0] max_x;
        logic signed [ELEM_W-1:0] max_y;
        logic signed [ELEM_W-1:0] max_z;
    } box_t;

    typedef struct {
        mat_preset_e preset;
        box_t        b;
        bit          typed;
        bit          vis;
    } box_row_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic signed [ELEM_W-1:0]   min_x     = '0;
    logic signed [ELEM_W-1:0]   min_y     = '0;
    logic signed [ELEM_W-1:0]   min_z     = '0;
    logic signed [ELEM_W-1:0]   max_x     = '0;
    logic signed [ELEM_W-1:0]   max_y     = '0;
    logic signed [ELEM_W-1:0]   max_z     = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       visible;

    logic [CFG_DATA_W-1:0] mat_cur [NUM_PAIRS];
    logic [CFG_DATA_W-1:0] mat_next [NUM_PAIRS];
    bit                    vis_expected_q [$];
    box_row_t              box_rows [$];
    bit                    want_vis;
    int                    mismatches   = 0;
    int                    quiet_cycles = 0;
    bit                    calm         = 1'b0;
    int                    calm_left    = 0;
    int                    ready_hold   = 0;

    frustum_box_cull u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .min_x     (min_x),
        .min_y     (min_y),
        .min_z     (min_z),
        .max_x     (max_x),
        .max_y     (max_y),
        .max_z     (max_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .visible   (visible)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [ELEM_W-1:0] mat_elem(input int col, input int row);
        logic [CFG_DATA_W-1:0] r;
        r = mat_cur[col * 2 + row / 2];
        return (row % 2 == 1) ? r[CFG_DATA_W-1:ELEM_W] : r[ELEM_W-1:0];
    endfunction

    function automatic void set_elem(input int col, input int row,
                                     input logic signed [ELEM_W-1:0] v);
        if (row % 2 == 1)
            mat_next[col * 2 + row / 2][CFG_DATA_W-1:ELEM_W] = v;
        else
            mat_next[col * 2 + row / 2][ELEM_W-1:0] = v;
    endfunction

    // Each plane is row 3 plus or minus row 0, 1 or 2; the box corner nearest the
    // inside of the plane is tested, with exact wide arithmetic.
    function automatic bit predict_visible(input box_t b);
        logic signed [127:0]      dist_sum;
        logic signed [127:0]      coef;
        logic signed [127:0]      pt;
        logic signed [127:0]      base;
        logic signed [127:0]      other;
        logic signed [ELEM_W-1:0] lo_c [3];
        logic signed [ELEM_W-1:0] hi_c [3];
        bit                       vis;
        vis     = 1'b1;
        lo_c[0] = b.min_x;
        lo_c[1] = b.min_y;
        lo_c[2] = b.min_z;
        hi_c[0] = b.max_x;
        hi_c[1] = b.max_y;
        hi_c[2] = b.max_z;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            dist_sum = '0;
            for (int k = 0; k < 4; k++)
            begin
                base  = mat_elem(k, 3);
                other = mat_elem(k, p / 2);
                coef  = (p % 2 == 1) ? base - other : base + other;
                if (k < 3)
                    pt = (coef >= 0) ? hi_c[k] : lo_c[k];
                else
                    pt = 128'sd1 <<< FRAC_BITS;
                dist_sum = dist_sum + coef * pt;
            end
            if (dist_sum < 0)
                vis = 1'b0;
        end
        return vis;
    endfunction

    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [ELEM_W-1:0] limit_value();
        case ($urandom_range(0, 5))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return '0;
            3:       return Q_ONE;
            4:       return -Q_ONE;
            default: return $urandom;
        endcase
    endfunction

    function automatic box_t rand_box();
        box_t                     b;
        logic signed [ELEM_W-1:0] lo_c [3];
        logic signed [ELEM_W-1:0] hi_c [3];
        logic signed [ELEM_W-1:0] t;
        int                       r;
        int                       c;
        int                       h;
        r = $urandom_range(0, 99);
        for (int k = 0; k < 3; k++)
        begin
            if (r < 70)
            begin
                c = $urandom_range(0, 32 * Q_UNIT);
                c = c - 16 * Q_UNIT;
                h = $urandom_range(0, 2 * Q_UNIT);
                lo_c[k] = c - h;
                hi_c[k] = c + h;
            end
            else if (r < 90)
            begin
                lo_c[k] = $urandom;
                hi_c[k] = $urandom;
            end
            else
            begin
                lo_c[k] = limit_value();
                hi_c[k] = limit_value();
            end
            if ($urandom_range(0, 19) == 0)
            begin
                t       = lo_c[k];
                lo_c[k] = hi_c[k];
                hi_c[k] = t;
            end
        end
        b.min_x = lo_c[0];
        b.min_y = lo_c[1];
        b.min_z = lo_c[2];
        b.max_x = hi_c[0];
        b.max_y = hi_c[1];
        b.max_z = hi_c[2];
        return b;
    endfunction

    function automatic void preset_matrix(input mat_preset_e p);
        for (int i = 0; i < NUM_PAIRS; i++)
            mat_next[i] = '0;
        for (int col = 0; col < 4; col++)
            for (int row = 0; row < 4; row++)
                case (p)
                    MAT_IDENT:     if (col == row) set_elem(col, row, Q_ONE);
                    MAT_POS_LIMIT: set_elem(col, row, Q_MAX);
                    MAT_NEG_LIMIT: set_elem(col, row, Q_MIN);
                    default:       ;
                endcase
    endfunction

    function automatic void build_matrix(input mat_mix_e mix);
        int v;
        for (int i = 0; i < NUM_PAIRS; i++)
            mat_next[i] = '0;
        case (mix)
            MIX_CAMERA:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    v = $urandom_range(Q_UNIT / 4, 2 * Q_UNIT);
                    set_elem(k, k, v);
                    v = $urandom_range(0, 8 * Q_UNIT);
                    set_elem(3, k, v - 4 * Q_UNIT);
                end
                set_elem(3, 3, Q_ONE);
                if ($urandom_range(0, 1) == 1)
                    set_elem(2, 3, -Q_ONE);
            end
            MIX_SMALL:
            begin
                for (int col = 0; col < 4; col++)
                    for (int row = 0; row < 4; row++)
                    begin
                        v = $urandom_range(0, 4 * Q_UNIT);
                        set_elem(col, row, v - 2 * Q_UNIT);
                    end
            end
            MIX_WIDE:
            begin
                for (int i = 0; i < NUM_PAIRS; i++)
                    mat_next[i] = {$urandom, $urandom};
            end
            default:
            begin
                for (int col = 0; col < 4; col++)
                    for (int row = 0; row < 4; row++)
                        set_elem(col, row, limit_value());
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < NUM_PAIRS)
            mat_cur[idx] = data;
    endtask

    task automatic load_matrix(input bit with_unused);
        for (int i = 0; i < NUM_PAIRS; i++)
            cfg_write(CFG_IDX_W'(i), mat_next[i]);
        if (with_unused)
            for (int i = NUM_PAIRS; i < 2 ** CFG_IDX_W; i++)
                cfg_write(CFG_IDX_W'(i), {$urandom, $urandom});
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_box(input box_t b, input bit typed, input bit vis);
        int gap;
        gap = gap_len();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        min_x    <= b.min_x;
        min_y    <= b.min_y;
        min_z    <= b.min_z;
        max_x    <= b.max_x;
        max_y    <= b.max_y;
        max_z    <= b.max_z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        vis_expected_q.push_back(typed ? vis : predict_visible(b));
    endtask

    task automatic wait_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (vis_expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input mat_preset_e p, input int lx, input int ly, input int lz,
                           input int hx, input int hy, input int hz,
                           input bit typed, input bit vis);
        box_row_t row;
        row.preset  = p;
        row.b.min_x = lx;
        row.b.min_y = ly;
        row.b.min_z = lz;
        row.b.max_x = hx;
        row.b.max_y = hy;
        row.b.max_z = hz;
        row.typed   = typed;
        row.vis     = vis;
        box_rows.push_back(row);
    endtask

    always @(negedge clk)
    begin
        if (calm_left == 0)
        begin
            calm      <= ($urandom_range(0, 3) == 0);
            calm_left <= $urandom_range(50, 300);
        end
        else
            calm_left <= calm_left - 1;
        if (ready_hold > 0)
        begin
            out_ready  <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_hold <= gap_len();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (vis_expected_q.size() == 0)
                report_mismatch("visible result with no box waiting");
            else
            begin
                want_vis = vis_expected_q.pop_front();
                if (visible !== want_vis)
                    report_mismatch($sformatf("visible %b, expected %b", visible, want_vis));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        mat_preset_e cur_preset;
        for (int i = 0; i < NUM_PAIRS; i++)
            mat_cur[i] = '0;

        add_row(MAT_ZERO, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1, 1'b1);
        add_row(MAT_ZERO, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b1, 1'b1);
        add_row(MAT_ZERO, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1);
        add_row(MAT_IDENT, -Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b1, 1'b1);
        add_row(MAT_IDENT, 2 * Q_ONE, -Q_ONE, -Q_ONE, 3 * Q_ONE, Q_ONE, Q_ONE, 1'b1, 1'b0);
        add_row(MAT_IDENT, -3 * Q_ONE, -Q_ONE, -Q_ONE, -2 * Q_ONE, Q_ONE, Q_ONE, 1'b1, 1'b0);
        add_row(MAT_IDENT, Q_ONE, -Q_ONE, -Q_ONE, 2 * Q_ONE, Q_ONE, Q_ONE, 1'b1, 1'b1);
        add_row(MAT_IDENT, Q_ONE + 1, -Q_ONE, -Q_ONE, 2 * Q_ONE, Q_ONE, Q_ONE, 1'b1, 1'b0);
        add_row(MAT_IDENT, -Q_ONE, -5 * Q_ONE, -Q_ONE, Q_ONE, -4 * Q_ONE, Q_ONE, 1'b1, 1'b0);
        add_row(MAT_IDENT, -Q_ONE, -Q_ONE, 5 * Q_ONE, Q_ONE, Q_ONE, 6 * Q_ONE, 1'b1, 1'b0);
        add_row(MAT_IDENT, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1, 1'b1);
        add_row(MAT_IDENT, 2 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE,
                -2 * Q_ONE, -2 * Q_ONE, -2 * Q_ONE, 1'b1, 1'b0);
        add_row(MAT_IDENT, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1);
        add_row(MAT_IDENT, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b1, 1'b1);
        add_row(MAT_POS_LIMIT, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b0, 1'b0);
        add_row(MAT_POS_LIMIT, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b0, 1'b0);
        add_row(MAT_POS_LIMIT, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
        add_row(MAT_POS_LIMIT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0, 1'b0);
        add_row(MAT_NEG_LIMIT, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b0, 1'b0);
        add_row(MAT_NEG_LIMIT, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b0, 1'b0);
        add_row(MAT_NEG_LIMIT, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
        add_row(MAT_NEG_LIMIT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0, 1'b0);

        repeat (12)
            @(negedge clk);
        rst_n <= 1'b1;

        cur_preset = MAT_ZERO;
        foreach (box_rows[i])
        begin
            if (box_rows[i].preset != cur_preset)
            begin
                wait_results();
                preset_matrix(box_rows[i].preset);
                load_matrix(box_rows[i].preset == MAT_IDENT);
                cur_preset = box_rows[i].preset;
            end
            send_box(box_rows[i].b, box_rows[i].typed, box_rows[i].vis);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_results();
            build_matrix(mat_mix_e'(ph % 4));
            load_matrix(ph == NUM_PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == 0 && i == PHASE_ITEMS / 2)
                    wait_results();
                send_box(rand_box(), 1'b0, 1'b0);
            end
        end

        wait_results();
        repeat (2 * PIPE_LAT)
            @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
